// ===== rtl/core/rdd_pkg.sv =====
// Shared types and constants of the remote dimmer decoder.
// No dependencies; every other file imports it.
package rdd_pkg;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_ENABLE   = 1'd1;

  localparam logic [4:0] FRAME_LEN  = 5'd7;
  localparam logic [7:0] SYNC_CODE  = 8'h5A;
  localparam logic [7:0] LEARN_KEY  = 8'h15;
  localparam logic [4:0] LEARN_THR  = 5'd20;
  localparam logic [4:0] LEARN_SAT  = 5'd31;

  localparam logic [3:0] KEY_ALL_ON  = 4'h5;
  localparam logic [3:0] KEY_ALL_OFF = 4'h9;
  localparam logic [3:0] KEY_UP      = 4'hC;
  localparam logic [3:0] KEY_DOWN    = 4'h4;
  localparam logic [3:0] KEY_RIGHT   = 4'hE;
  localparam logic [3:0] KEY_LEFT    = 4'hF;

  localparam logic [3:0] ON_KEYS  [4] = '{4'h8, 4'hD, 4'h7, 4'h2};
  localparam logic [3:0] OFF_KEYS [4] = '{4'hB, 4'h3, 4'hA, 4'h6};

  localparam logic [7:0] TARGET_BASE = 8'd101;
  localparam logic [7:0] TARGET_ALL  = 8'd255;
  localparam logic [7:0] LEVEL_FLOOR = 8'd2;

  localparam int MAX_RESULTS = 5;

  typedef enum logic [2:0] {
    MSG_STATUS     = 3'd0,
    MSG_ON_OFF     = 3'd1,
    MSG_NIGHT      = 3'd2,
    MSG_MOTION     = 3'd3,
    MSG_BRIGHTNESS = 3'd4,
    MSG_STORE_ADDR = 3'd5
  } msg_kind_t;

  typedef struct packed {
    logic [4:0] packet_length;
    logic [7:0] sync_byte;
    logic [7:0] address_high;
    logic [7:0] address_low;
    logic [7:0] group_byte;
    logic [7:0] key_byte;
    logic [7:0] roll_count;
  } in_item_t;

  typedef struct packed {
    msg_kind_t   msg_kind;
    logic [7:0]  target_id;
    logic        switch_value;
    logic [7:0]  warm_out;
    logic [7:0]  cold_out;
    logic [15:0] learned_address;
    logic        frame_valid;
    logic        first_press;
    logic        last;
  } out_item_t;

endpackage

// ===== rtl/core/rdd_if.sv =====
// Valid/ready channels for packets in and result items out.
// Depends on rdd_pkg for the payload types.
interface rdd_in_if;
  import rdd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface rdd_out_if;
  import rdd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/rf_remote_dimmer_decoder.sv =====
// Remote dimmer decoder: a packet is registered on acceptance and decoded, once the
// result buffer is free, into a buffer of one to five result items. Items leave one
// per cycle while out_ch.ready is high; a packet holds the output until all of its
// results (1 to 5) have left the result buffer.
// Synchronous active-low reset clears lamp, remote and handshake state and sets
// max_brightness to 255 and learn_enable to 0.
module rf_remote_dimmer_decoder #(
  parameter int HOLD_STEP = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdd_pkg::CFG_W-1:0]     cfg_wdata,
  rdd_in_if.sink                        in_ch,
  rdd_out_if.source                     out_ch
);
  import rdd_pkg::*;

  localparam logic [8:0] HOLD_W     = 9'(HOLD_STEP);
  localparam logic [8:0] FLOOR_HELD = 9'(HOLD_STEP + 2);

  // configuration
  logic [7:0] max_r;
  logic       learn_en_r;

  // input register
  in_item_t in_r;
  logic     in_valid_r;

  // result buffer
  out_item_t  res_r [MAX_RESULTS];
  logic [2:0] idx_r;
  logic       res_valid_r;

  // decoder state
  logic [15:0] remote_r, remote_nxt;
  logic [4:0]  lcount_r, lcount_nxt;
  logic [7:0]  lroll_r, lroll_nxt;
  logic [3:0]  prev_r, prev_nxt;
  logic        fpf_r, fpf_nxt;
  logic [3:0]  on_r, on_nxt;
  logic [3:0]  motion_r, motion_nxt;
  logic [3:0]  night_r, night_nxt;
  logic [7:0]  warm_r [4];
  logic [7:0]  warm_nxt [4];
  logic [7:0]  cold_r [4];
  logic [7:0]  cold_nxt [4];

  out_item_t  lst [MAX_RESULTS];
  logic [2:0] n;
  logic       frame_ok, fresh, ok, held;
  logic [3:0] key;
  logic [15:0] addr;
  logic [4:0] lcount_inc;
  logic [8:0] step;
  logic       is_on, is_off;
  logic [1:0] key_grp;
  logic [7:0] adj_w, adj_c;
  logic       out_fire, buf_free, proc;

  function automatic out_item_t mk(msg_kind_t kind, logic [7:0] target, logic sw,
                                   logic [7:0] w, logic [7:0] c, logic [15:0] a);
    out_item_t r;
    r = '0;
    r.msg_kind        = kind;
    r.target_id       = target;
    r.switch_value    = sw;
    r.warm_out        = w;
    r.cold_out        = c;
    r.learned_address = a;
    return r;
  endfunction

  function automatic logic [7:0] inc_sat(logic [7:0] v, logic [8:0] s, logic [7:0] mx);
    logic [8:0] sum;
    sum = {1'b0, v} + s;
    return (sum > {1'b0, mx}) ? mx : sum[7:0];
  endfunction

  function automatic logic [7:0] dec_floor(logic [7:0] v, logic h);
    if (h) begin
      return ({1'b0, v} > FLOOR_HELD) ? v - HOLD_W[7:0] : v;
    end
    return (v > LEVEL_FLOOR) ? v - 8'd1 : v;
  endfunction

  // handshake
  assign out_fire     = res_valid_r && out_ch.ready;
  assign buf_free     = !res_valid_r || (out_fire && res_r[idx_r].last);
  assign proc         = in_valid_r && buf_free;
  assign in_ch.ready  = !in_valid_r || buf_free;
  assign out_ch.valid = res_valid_r;
  assign out_ch.data  = res_r[idx_r];

  // decode
  always_comb begin
    remote_nxt = remote_r;
    lcount_nxt = lcount_r;
    lroll_nxt  = lroll_r;
    prev_nxt   = prev_r;
    fpf_nxt    = fpf_r;
    on_nxt     = on_r;
    motion_nxt = motion_r;
    night_nxt  = night_r;
    warm_nxt   = warm_r;
    cold_nxt   = cold_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      lst[i] = '0;
    end
    n = 3'd0;
    adj_w = '0;
    adj_c = '0;

    frame_ok   = (in_r.packet_length == FRAME_LEN) && (in_r.sync_byte == SYNC_CODE);
    fresh      = frame_ok && (in_r.roll_count != lroll_r);
    addr       = {in_r.address_high, in_r.address_low};
    key        = in_r.key_byte[3:0];
    held       = (in_r.key_byte[7:4] != 4'd0);
    step       = held ? HOLD_W : 9'd1;
    lcount_inc = (lcount_r < LEARN_SAT) ? lcount_r + 5'd1 : lcount_r;

    is_on   = 1'b0;
    is_off  = 1'b0;
    key_grp = 2'd0;
    for (int g = 0; g < 4; g++) begin
      if (!is_on && !is_off) begin
        if (key == ON_KEYS[g]) begin
          is_on   = 1'b1;
          key_grp = 2'(g);
        end else if (key == OFF_KEYS[g]) begin
          is_off  = 1'b1;
          key_grp = 2'(g);
        end
      end
    end

    ok = 1'b0;
    if (fresh) begin
      lroll_nxt = in_r.roll_count;
      if (addr == remote_r) begin
        ok = 1'b1;
      end else if (learn_en_r && in_r.key_byte == LEARN_KEY) begin
        lcount_nxt = lcount_inc;
        if (lcount_inc >= LEARN_THR) begin
          remote_nxt = addr;
          lst[n] = mk(MSG_STORE_ADDR, 8'd0, 1'b0, 8'd0, 8'd0, addr);
          n = n + 3'd1;
          ok = 1'b1;
        end
      end
    end

    if (ok) begin
      if (key == KEY_ALL_ON) begin
        on_nxt = 4'hF;
        night_nxt = held ? 4'hF : 4'h0;
        if (!held) begin
          motion_nxt = 4'h0;
          fpf_nxt = (prev_r != key);
          prev_nxt = key;
          lst[n] = mk(MSG_NIGHT, TARGET_ALL, 1'b0, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
          lst[n] = mk(MSG_ON_OFF, TARGET_ALL, 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end else begin
          fpf_nxt = 1'b0;
          lst[n] = mk(MSG_NIGHT, TARGET_ALL, 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end
      end else if (key == KEY_ALL_OFF) begin
        if (!held) begin
          motion_nxt = 4'hF;
          fpf_nxt = (prev_r != key);
          prev_nxt = key;
          lst[n] = mk(MSG_MOTION, TARGET_ALL, 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end else begin
          motion_nxt = 4'h0;
          on_nxt = 4'h0;
          fpf_nxt = 1'b0;
          lst[n] = mk(MSG_MOTION, TARGET_ALL, 1'b0, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
          lst[n] = mk(MSG_ON_OFF, TARGET_ALL, 1'b0, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end
      end else if (is_on) begin
        on_nxt[key_grp] = 1'b1;
        if (!held) begin
          motion_nxt[key_grp] = 1'b0;
          night_nxt[key_grp] = 1'b0;
          fpf_nxt = (prev_r != key);
          prev_nxt = key;
          lst[n] = mk(MSG_ON_OFF, TARGET_BASE + 8'(key_grp), 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end else begin
          night_nxt[key_grp] = 1'b1;
          fpf_nxt = 1'b0;
          lst[n] = mk(MSG_NIGHT, TARGET_BASE + 8'(key_grp), 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end
      end else if (is_off) begin
        if (!held) begin
          motion_nxt[key_grp] = 1'b1;
          fpf_nxt = (prev_r != key);
          prev_nxt = key;
          lst[n] = mk(MSG_MOTION, TARGET_BASE + 8'(key_grp), 1'b1, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end else begin
          motion_nxt[key_grp] = 1'b0;
          on_nxt[key_grp] = 1'b0;
          fpf_nxt = 1'b0;
          lst[n] = mk(MSG_ON_OFF, TARGET_BASE + 8'(key_grp), 1'b0, 8'd0, 8'd0, 16'd0);
          n = n + 3'd1;
        end
      end else if (key == KEY_UP || key == KEY_DOWN || key == KEY_RIGHT ||
                   key == KEY_LEFT) begin
        fpf_nxt = 1'b0;
        for (int g = 0; g < 4; g++) begin
          if (in_r.group_byte <= 8'd4 && on_r[g] &&
              (in_r.group_byte == 8'd0 || in_r.group_byte == 8'(g + 1))) begin
            case (key)
              KEY_UP: begin
                adj_w = inc_sat(warm_r[g], step, max_r);
                adj_c = inc_sat(cold_r[g], step, max_r);
              end
              KEY_DOWN: begin
                adj_w = dec_floor(warm_r[g], held);
                adj_c = dec_floor(cold_r[g], held);
              end
              KEY_RIGHT: begin
                adj_w = dec_floor(warm_r[g], held);
                if (held) begin
                  adj_c = inc_sat(cold_r[g], step, max_r);
                end else begin
                  adj_c = (cold_r[g] < max_r) ? cold_r[g] + 8'd1 : cold_r[g];
                end
              end
              default: begin
                adj_w = inc_sat(warm_r[g], step, max_r);
                adj_c = dec_floor(cold_r[g], held);
              end
            endcase
            warm_nxt[g] = adj_w;
            cold_nxt[g] = adj_c;
            // a learn item plus four level items fills the buffer
            if (n < 3'(MAX_RESULTS)) begin
              lst[n] = mk(MSG_BRIGHTNESS, TARGET_BASE + 8'(g), 1'b0, adj_w, adj_c, 16'd0);
              n = n + 3'd1;
            end
          end
        end
        if (key != KEY_DOWN) begin
          for (int g = 0; g < 4; g++) begin
            if (warm_nxt[g] > max_r) warm_nxt[g] = max_r;
            if (cold_nxt[g] > max_r) cold_nxt[g] = max_r;
          end
        end
      end
    end

    // closing status; with a full buffer the status bits ride on the final item
    if (n < 3'(MAX_RESULTS)) begin
      lst[n] = mk(MSG_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 16'd0);
      lst[n].frame_valid = frame_ok;
      lst[n].first_press = fpf_nxt;
      lst[n].last        = 1'b1;
    end else begin
      lst[MAX_RESULTS-1].frame_valid = frame_ok;
      lst[MAX_RESULTS-1].first_press = fpf_nxt;
      lst[MAX_RESULTS-1].last        = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r      <= 8'd255;
      learn_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BRIGHTNESS: max_r      <= cfg_wdata[7:0];
        CFG_LEARN_ENABLE:   learn_en_r <= cfg_wdata[0];
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
    if (proc) begin
      res_r <= lst;
    end
  end

  // handshake control and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      remote_r    <= '0;
      lcount_r    <= '0;
      lroll_r     <= '0;
      prev_r      <= '0;
      fpf_r       <= 1'b0;
      on_r        <= '0;
      motion_r    <= '0;
      night_r     <= '0;
      for (int g = 0; g < 4; g++) begin
        warm_r[g] <= '0;
        cold_r[g] <= '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end

      if (proc) begin
        res_valid_r <= 1'b1;
        idx_r       <= 3'd0;
        remote_r    <= remote_nxt;
        lcount_r    <= lcount_nxt;
        lroll_r     <= lroll_nxt;
        prev_r      <= prev_nxt;
        fpf_r       <= fpf_nxt;
        on_r        <= on_nxt;
        motion_r    <= motion_nxt;
        night_r     <= night_nxt;
        warm_r      <= warm_nxt;
        cold_r      <= cold_nxt;
      end else if (out_fire) begin
        // advance through the buffer, drop it after the closing item
        if (res_r[idx_r].last) begin
          res_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

endmodule
